// ----- src/dwf_pkg.sv -----
// Shared constants, item kinds and the command type of the duplicate word filter.
// Used by the front end, the back end and the top level; depends on nothing.
package dwf_pkg;

   localparam int MAX_WORD_LEN = 16;
   localparam int MAX_WORDS    = 64;

   localparam int WLEN_W    = $clog2(MAX_WORD_LEN + 1);
   localparam int IDX_W     = $clog2(MAX_WORD_LEN);
   localparam int CNT_W     = $clog2(MAX_WORDS + 1);
   localparam int ADDR_W    = $clog2(MAX_WORDS);
   localparam int WORD_BITS = 8 * MAX_WORD_LEN;
   localparam int ROW_BITS  = WORD_BITS + WLEN_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   localparam logic [1:0] KIND_CHAR     = 2'd0;
   localparam logic [1:0] KIND_WORD_END = 2'd1;
   localparam logic [1:0] KIND_SENT_END = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } cmd_type;

endpackage

// ----- src/dwf_front.sv -----
// Front end of the duplicate word filter: accepts input items, classifies them
// and holds them in a short command queue for the back end. Depends on dwf_pkg.
module dwf_front
   import dwf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);

   cmd_type              q_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   fill_ff, fill_in;
   cmd_type              new_cmd;
   logic                 push, pop;

   always_comb begin
      new_cmd.data = req_tdata;
      if (req_tuser) begin
         new_cmd.kind = KIND_SENT_END;
      end else if (req_tdata == SPACE_CHAR) begin
         new_cmd.kind = KIND_WORD_END;
      end else begin
         new_cmd.kind = KIND_CHAR;
      end
   end

   assign req_tready = (fill_ff != Q_CNT_W'(QUEUE_DEPTH));
   assign cmd_valid  = (fill_ff != '0);
   assign cmd        = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = Q_CNT_W'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = Q_CNT_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- src/dwf_back.sv -----
// Back end of the duplicate word filter: buffers the open word, searches the
// table of distinct words, records new ones and emits the filtered bytes.
// Depends on dwf_pkg.
module dwf_back
   import dwf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_ready,
   input  cmd_type    cmd,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser
);

   localparam logic [1:0] STATE_IDLE   = 2'd0;
   localparam logic [1:0] STATE_SEARCH = 2'd1;
   localparam logic [1:0] STATE_EMIT   = 2'd2;

   logic [ROW_BITS-1:0]  mem [MAX_WORDS];

   logic [1:0]           state_ff, state_in;
   logic [WLEN_W-1:0]    len_ff, len_in;
   logic                 overlong_ff, overlong_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 eos_ff, eos_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [ROW_BITS-1:0]  row_ff;
   logic                 trunc_ff, trunc_in;
   logic                 full_ff, full_in;
   logic [WLEN_W-1:0]    left_ff, left_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_trunc_ff, rsp_trunc_in;
   logic                 rsp_full_ff, rsp_full_in;

   logic [WORD_BITS-1:0] mask;
   logic                 match, issue, load, mem_we;

   // Only the bytes below the open word's length take part in the compare.
   always_comb begin
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
         mask[8*k +: 8] = (WLEN_W'(k) < len_ff) ? 8'hFF : 8'h00;
      end
   end

   assign match = cmp_valid_ff
                  && (row_ff[ROW_BITS-1 -: WLEN_W] == len_ff)
                  && (((row_ff[WORD_BITS-1:0] ^ word_ff) & mask) == '0);
   assign issue = (state_ff == STATE_SEARCH) && (issue_ff != count_ff) && !match;
   assign load  = (state_ff == STATE_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign cmd_ready = (state_ff == STATE_IDLE);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      overlong_in  = overlong_ff;
      word_in      = word_ff;
      eos_in       = eos_ff;
      count_in     = count_ff;
      issue_in     = issue ? CNT_W'(issue_ff + 1'b1) : issue_ff;
      cmp_valid_in = issue;
      trunc_in     = trunc_ff;
      full_in      = full_ff;
      left_in      = left_ff;
      mem_we       = 1'b0;
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || load;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;
      rsp_full_in  = rsp_full_ff;

      unique case (state_ff)
         STATE_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == KIND_CHAR) begin
                  if (len_ff < WLEN_W'(MAX_WORD_LEN)) begin
                     word_in[8*int'(len_ff[IDX_W-1:0]) +: 8] = cmd.data;
                     len_in = WLEN_W'(len_ff + 1'b1);
                  end else begin
                     overlong_in = 1'b1;
                  end
               end else begin
                  eos_in   = (cmd.kind == KIND_SENT_END);
                  trunc_in = overlong_ff;
                  full_in  = 1'b0;
                  left_in  = '0;
                  issue_in = '0;
                  // An empty word goes straight to its trailing space.
                  state_in = (len_ff == '0) ? STATE_EMIT : STATE_SEARCH;
               end
            end
         end
         STATE_SEARCH: begin
            if (match) begin
               state_in = STATE_EMIT;
            end else if (!cmp_valid_ff && (issue_ff == count_ff)) begin
               state_in = STATE_EMIT;
               left_in  = len_ff;
               if (count_ff < CNT_W'(MAX_WORDS)) begin
                  mem_we   = 1'b1;
                  count_in = CNT_W'(count_ff + 1'b1);
               end else begin
                  full_in = 1'b1;
               end
            end
         end
         STATE_EMIT: begin
            if (load) begin
               rsp_trunc_in = trunc_ff;
               rsp_full_in  = full_ff;
               if (left_ff != '0) begin
                  rsp_byte_in = word_ff[7:0];
                  rsp_last_in = 1'b0;
                  word_in     = word_ff >> 8;
                  left_in     = WLEN_W'(left_ff - 1'b1);
               end else begin
                  rsp_byte_in = SPACE_CHAR;
                  rsp_last_in = 1'b1;
                  len_in      = '0;
                  overlong_in = 1'b0;
                  state_in    = STATE_IDLE;
                  if (eos_ff) begin
                     count_in = '0;
                  end
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         len_ff       <= '0;
         overlong_ff  <= 1'b0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         overlong_ff  <= overlong_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      eos_ff       <= eos_in;
      issue_ff     <= issue_in;
      trunc_ff     <= trunc_in;
      full_ff      <= full_in;
      left_ff      <= left_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
      rsp_full_ff  <= rsp_full_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_W-1:0]] <= {len_ff, word_ff};
      end
      if (issue) begin
         row_ff <= mem[issue_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_full_ff, rsp_trunc_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_WORDS))
      else $error("word table count exceeds its depth");

   a_overlong_len: assert property (@(posedge clock) disable iff (reset)
      overlong_ff |-> (len_ff == WLEN_W'(MAX_WORD_LEN)))
      else $error("overlong flag set while the word buffer is not full");

   a_last_space: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_byte_ff == SPACE_CHAR))
      else $error("final byte of a word end is not a space");

   a_record_new: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (!match && (len_ff != '0) && (count_ff < CNT_W'(MAX_WORDS))))
      else $error("word recorded although known, empty or table full");

endmodule

// ----- src/duplicate_word_filter_unit.sv -----
// Duplicate word filter: takes sentence text one item (byte) at a time and
// passes each distinct word once, followed by a space; a repeated word leaves
// only the space. A word end (space or sentence end) walks the table of words
// seen so far in this sentence, one table row per cycle from a single-port
// row memory with registered read, then emits the word and its space at one
// byte per cycle while the output side is ready. A four-entry command queue
// lets input items arrive while a word end is still in work. Words are cut
// to 16 bytes (word_truncated), and at most 64 words are recorded per
// sentence (table_full). There is no clearing pass after reset.
// Depends on dwf_pkg, dwf_front and dwf_back.
module duplicate_word_filter_unit
   import dwf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tuser,   // end_of_sentence
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast,   // last
   output logic [1:0] rsp_tuser    // word_truncated, table_full
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   dwf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   dwf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for duplicate_word_filter_unit: streams sentences in, predicts the
// filtered text in step with each accepted item and checks every output byte.
// Depends on dwf_pkg and the duplicate_word_filter_unit RTL.
module tb_top
   import dwf_pkg::*;
();

   typedef logic [7:0] text_queue_type[$];

   typedef struct {
      logic [7:0] data;
      logic       eos;
      bit         after_drain;   // hold this item back until all text has come out
   } sentence_item_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       trunc;
      logic       full;
   } text_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // in_byte
   logic       req_tuser = 1'b0;    // end_of_sentence
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // out_byte
   logic       rsp_tlast;           // last
   logic [1:0] rsp_tuser;           // word_truncated, table_full

   sentence_item_type sentence_items[$];
   text_byte_type     predicted_text[$];
   int                items_taken = 0;
   int                results_seen = 0;
   int                mismatches = 0;

   // Predictor state: the open word and the distinct words of this sentence.
   logic [7:0] open_word[MAX_WORD_LEN];
   int         open_len = 0;
   bit         open_overlong = 0;
   logic [7:0] known_words[MAX_WORDS][MAX_WORD_LEN];
   int         known_len[MAX_WORDS];
   int         known_count = 0;

   duplicate_word_filter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

   // Every third stretch of 40 items runs with no idling at all.
   function automatic int draw_wait(input int count);
      if ((count / 40) % 3 == 2)
         return 0;
      return $urandom_range(0, 13);
   endfunction

   function automatic bit open_word_known();
      bit same;
      for (int w = 0; w < known_count; w++) begin
         if (known_len[w] == open_len) begin
            same = 1;
            for (int k = 0; k < open_len; k++)
               if (known_words[w][k] != open_word[k])
                  same = 0;
            if (same)
               return 1;
         end
      end
      return 0;
   endfunction

   task automatic close_word();
      text_byte_type tb;
      bit            emit;
      bit            full;
      emit = 0;
      full = 0;
      if (open_len > 0 && !open_word_known()) begin
         emit = 1;
         if (known_count < MAX_WORDS) begin
            for (int k = 0; k < open_len; k++)
               known_words[known_count][k] = open_word[k];
            known_len[known_count] = open_len;
            known_count++;
         end else begin
            full = 1;
         end
      end
      tb.trunc = open_overlong;
      tb.full = full;
      tb.last = 1'b0;
      if (emit) begin
         for (int k = 0; k < open_len; k++) begin
            tb.data = open_word[k];
            predicted_text.push_back(tb);
         end
      end
      tb.data = SPACE_CHAR;
      tb.last = 1'b1;
      predicted_text.push_back(tb);
      open_len = 0;
      open_overlong = 0;
   endtask

   task automatic filter_item(input logic [7:0] data, input logic eos);
      if (eos) begin
         close_word();
         known_count = 0;
      end else if (data == SPACE_CHAR) begin
         close_word();
      end else if (open_len < MAX_WORD_LEN) begin
         open_word[open_len] = data;
         open_len++;
      end else begin
         open_overlong = 1;
      end
   endtask

   task automatic add_item(input logic [7:0] data, input logic eos, input bit drain = 0);
      sentence_item_type it;
      it.data = data;
      it.eos = eos;
      it.after_drain = drain;
      sentence_items.push_back(it);
   endtask

   task automatic add_word(input text_queue_type w, input bit drain = 0);
      foreach (w[k])
         add_item(w[k], 1'b0, drain && k == 0);
   endtask

   function automatic logic [7:0] random_letter();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == SPACE_CHAR);
      return b;
   endfunction

   function automatic text_queue_type random_word();
      text_queue_type w;
      int             len;
      len = ($urandom_range(0, 6) == 0) ? $urandom_range(MAX_WORD_LEN + 1, MAX_WORD_LEN + 4)
                                        : $urandom_range(1, 6);
      for (int k = 0; k < len; k++)
         w.push_back(random_letter());
      return w;
   endfunction

   // Sender: one item on the bus at a time, with a random gap after each.
   always @(posedge clock) begin : sender
      sentence_item_type nxt;
      int                gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            filter_item(req_tdata, req_tuser);
            items_taken++;
            gap_left = draw_wait(items_taken);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (sentence_items.size() > 0 &&
                         !(sentence_items[0].after_drain && predicted_text.size() != 0)) begin
               nxt = sentence_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.data;
               req_tuser <= nxt.eos;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls per item, plus one long hold-off so the block fills up.
   always @(posedge clock) begin : receiver
      text_byte_type want;
      int            stall_left;
      int            hold_left;
      bit            hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         hold_done = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (predicted_text.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected item: byte %h last %b flags %b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = predicted_text.pop_front();
               if (rsp_tdata !== want.data || rsp_tlast !== want.last ||
                   rsp_tuser[0] !== want.trunc || rsp_tuser[1] !== want.full) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"item %0d: expected byte %h last %b trunc %b full %b,",
                               " got byte %h last %b trunc %b full %b"},
                              results_seen, want.data, want.last, want.trunc, want.full,
                              rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[1]);
               end
            end
            stall_left = draw_wait(results_seen);
         end
         if (!hold_done && results_seen >= 150) begin
            hold_done = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      text_queue_type vocab[8];
      text_queue_type w;
      int             directed_count;
      int             sentence_no;
      int             n_words;
      int             pick;

      // Leading space, a new word with the extreme bytes, then its repeat closed
      // by an end of sentence whose byte is a space and must be ignored.
      add_item(SPACE_CHAR, 1'b0);
      add_item(8'h00, 1'b0);
      add_item(8'hff, 1'b0);
      add_item(SPACE_CHAR, 1'b0);
      add_item(8'h00, 1'b0);
      add_item(8'hff, 1'b0);
      add_item(SPACE_CHAR, 1'b1);
      // End of sentence on an empty word.
      add_item(8'h41, 1'b1);
      // Overlong word, a double space, then close the sentence.
      for (int i = 0; i < MAX_WORD_LEN + 1; i++)
         add_item(8'(8'h61 + i), 1'b0);
      add_item(SPACE_CHAR, 1'b0);
      add_item(SPACE_CHAR, 1'b0);
      add_item(8'h00, 1'b1);
      directed_count = sentence_items.size();

      foreach (vocab[k])
         vocab[k] = random_word();
      sentence_no = 0;
      while (sentence_items.size() - directed_count < 330) begin
         sentence_no++;
         if (sentence_no == 3) begin
            // Fill the word table past its end; a repeat then still leaves only
            // a space, while new words pass through flagged.
            for (int i = 0; i < MAX_WORDS + 2; i++) begin
               add_item(8'(8'd33 + i), 1'b0, i == 0);
               add_item(SPACE_CHAR, 1'b0);
            end
            add_item(8'd40, 1'b0);
            add_item(SPACE_CHAR, 1'b0);
            add_item(8'd200, 1'b0);
            add_item(8'd201, 1'b0);
            add_item(SPACE_CHAR, 1'b0);
            add_item(8'd202, 1'b0);
            add_item(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            if ($urandom_range(0, 2) == 0)
               vocab[$urandom_range(0, 7)] = random_word();
            n_words = $urandom_range(1, 12);
            for (int i = 0; i < n_words; i++) begin
               pick = $urandom_range(0, 9);
               if (pick == 0) begin
                  add_item(8'($urandom_range(0, 255)), 1'b0);
               end else if (pick == 1) begin
                  add_item(SPACE_CHAR, 1'b0);
               end else begin
                  if (pick <= 6) begin
                     w = vocab[$urandom_range(0, 7)];
                     // Bytes past the cut-off do not make a word distinct.
                     for (int k = MAX_WORD_LEN; k < w.size(); k++)
                        w[k] = random_letter();
                  end else begin
                     w = random_word();
                  end
                  add_word(w, i == 0 && $urandom_range(0, 7) == 0);
               end
               if (i < n_words - 1 || $urandom_range(0, 1) == 0)
                  add_item(SPACE_CHAR, 1'b0);
            end
            add_item(8'($urandom_range(0, 255)), 1'b1);
         end
      end

      while (sentence_items.size() > 0 || req_tvalid)
         @(posedge clock);
      while (predicted_text.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (predicted_text.size() != 0)
         mismatches++;
      if (mismatches == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
